FILE: rtl/arpc_pkg.sv
// arpc_pkg: shared types and constants of the arp cache with pending queues
// field widths, request codes, result codes and the sequencer state type
// no dependencies
`default_nettype none
package arpc_pkg;

	localparam int IP_W   = 32;
	localparam int MAC_W  = 48;
	localparam int TIME_W = 48;
	localparam int HDL_W  = 16;
	localparam int MQ_W   = 7;
	localparam int TMO_W  = 40;
	localparam int CFG_IDX_W = 1;

	localparam logic [1:0] MODE_QUEUE = 2'd0;
	localparam logic [1:0] MODE_LEARN = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	localparam logic [1:0] KIND_SEND   = 2'd0;
	localparam logic [1:0] KIND_DROP   = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_QUEUED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 1'd1;

	localparam logic [MQ_W-1:0]  MAX_QUEUED_RST = 7'd40;
	localparam logic [TMO_W-1:0] TIMEOUT_RST    = 40'd30000000;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_POP,
		ST_POP_WAIT,
		ST_PUSH,
		ST_WRITE,
		ST_REJECT
	} arpc_state_t;

endpackage
`default_nettype wire

FILE: rtl/arpc_ram.sv
// arpc_ram: simple dual port synchronous memory, one write and one read port
// read data registered; no dependencies
`default_nettype none
module arpc_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16,
	parameter int AW    = 6
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: rtl/arp_cache_with_pending_queue_unit.sv
// arp cache top level: slot table memory, pending handle memory, sequencer
// depends on arpc_pkg and arpc_ram
//
// channel   dir   handshake          payload
// s_*       in    tvalid/tready      tuser=mode, tdata=ip,handle,mac,now
// m_*       out   tvalid/tready      tuser=kind, tdata=handle,mac, tlast
// cfg_*     in    cfg_we             cfg_index, cfg_data
//
// one request at a time. lookup walks the slot memory one entry a cycle and
// stops at the first hit. each handle sent or dropped passes the pop and
// pop-wait states, a push the push state, and the write state writes back.
// after reset a clearing pass over all ENTRIES slots runs before s_tready rises.
// a result waits in the output register; a stalled m_tready holds pops and rejects.
`default_nettype none
module arp_cache_with_pending_queue_unit #(
	parameter int ENTRIES     = 64,
	parameter int QUEUE_DEPTH = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// slave side request
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [143:0] s_tdata,  // ip_addr, pkt_handle, mac_addr, now_us
	input  wire logic [1:0]   s_tuser,  // mode
	// master side result
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [63:0]       m_tdata,  // out_handle, dest_mac
	output logic [1:0]        m_tuser,  // kind
	output logic              m_tlast,
	// configuration writes
	input  wire logic                           cfg_we,
	input  wire logic [arpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [arpc_pkg::TMO_W-1:0]     cfg_data
);
	import arpc_pkg::*;

	localparam int EW  = $clog2(ENTRIES);
	localparam int HW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int QAW = $clog2(ENTRIES * QUEUE_DEPTH);
	// slot word: used, known, head, count, ip, mac, deadline from bit 0 up
	localparam int SW  = 2 + HW + CW + IP_W + MAC_W + TIME_W;

	// configuration registers
	logic [MQ_W-1:0]  max_q_q;
	logic [TMO_W-1:0] tmo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q_q <= MAX_QUEUED_RST;
			tmo_q   <= TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_QUEUED: max_q_q <= cfg_data[MQ_W-1:0];
				CFG_TIMEOUT:    tmo_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective queue limit, clamped to 1..QUEUE_DEPTH
	logic [8:0]    mq9;
	logic [CW-1:0] limit;
	assign mq9 = {2'b0, max_q_q};
	always_comb begin
		if (mq9 == 9'd0) begin
			limit = CW'(1);
		end else if (mq9 > 9'(QUEUE_DEPTH)) begin
			limit = CW'(QUEUE_DEPTH);
		end else begin
			limit = CW'(mq9);
		end
	end

	arpc_state_t state_q, state_d;

	// latched request
	logic [1:0]        mode_q;
	logic [IP_W-1:0]   ip_q;
	logic [HDL_W-1:0]  handle_q;
	logic [MAC_W-1:0]  mac_q;
	logic [TIME_W-1:0] now_q;

	// scan pipeline
	logic [EW:0]   scan_idx_q;
	logic          chk_v_s1;
	logic [EW-1:0] chk_idx_s1;
	logic [EW-1:0] clr_idx_q;

	// working copy of the selected entry
	logic              found_q;
	logic              free_v_q;
	logic [EW-1:0]     free_idx_q;
	logic [EW-1:0]     cur_idx_q;
	logic              known_q;
	logic [IP_W-1:0]   ipw_q;
	logic [MAC_W-1:0]  macw_q;
	logic [TIME_W-1:0] dl_q;
	logic [HW-1:0]     head_q;
	logic [CW-1:0]     count_q;

	// slot memory ports
	logic          slot_we, slot_re;
	logic [EW-1:0] slot_waddr;
	logic [SW-1:0] slot_wdata, slot_rdata;

	logic              r_used;
	logic [HW-1:0]     r_head;
	logic [CW-1:0]     r_count;
	logic [IP_W-1:0]   r_ip;
	logic [MAC_W-1:0]  r_mac;
	logic [TIME_W-1:0] r_dl;
	logic              r_known;
	assign {r_dl, r_mac, r_ip, r_count, r_head, r_known, r_used} = slot_rdata;

	// queue memory ports
	logic             q_we, q_re;
	logic [QAW-1:0]   q_waddr, q_raddr, q_base;
	logic [HDL_W-1:0] q_rdata;

	// scan decisions on the word read last cycle
	logic issue_en, hit, scan_end;
	assign issue_en = (state_q == ST_SCAN) && (scan_idx_q < (EW+1)'(ENTRIES));
	assign hit = chk_v_s1 && r_used &&
		((mode_q == MODE_TICK) ? (now_q >= r_dl) : (r_ip == ip_q));
	assign scan_end = chk_v_s1 && (chk_idx_s1 == EW'(ENTRIES - 1));

	// queue pointer arithmetic
	logic [CW-1:0] cnt_dec;
	logic [HW-1:0] head_inc;
	logic [CW:0]   pos_sum;
	logic [CW:0]   pos;
	logic          more;
	assign cnt_dec  = count_q - CW'(1);
	assign head_inc = (head_q == HW'(QUEUE_DEPTH - 1)) ? '0 : head_q + HW'(1);
	assign pos_sum  = (CW+1)'(head_q) + (CW+1)'(count_q);
	assign pos      = (pos_sum >= (CW+1)'(QUEUE_DEPTH)) ?
		pos_sum - (CW+1)'(QUEUE_DEPTH) : pos_sum;
	// drop loop stops below the limit, send and expire loops drain the queue
	assign more = (mode_q == MODE_QUEUE) ? (cnt_dec >= limit) : (cnt_dec != '0);
	assign q_base = QAW'(cur_idx_q) * QAW'(QUEUE_DEPTH);

	// saturating deadline
	logic [TIME_W:0]   dl_sum;
	logic [TIME_W-1:0] new_dl;
	assign dl_sum = {1'b0, now_q} + (TIME_W+1)'(tmo_q);
	assign new_dl = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];

	// output register
	logic              out_free, out_load;
	logic              m_tvalid_q;
	logic [1:0]        kind_q;
	logic [HDL_W-1:0]  oh_q;
	logic [MAC_W-1:0]  omac_q;
	logic              olast_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = out_free && ((state_q == ST_POP_WAIT) || (state_q == ST_REJECT));

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {omac_q, oh_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = olast_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_idx_q == EW'(ENTRIES - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid && (s_tuser == MODE_QUEUE || s_tuser == MODE_LEARN ||
					s_tuser == MODE_TICK)) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (hit || scan_end) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				case (mode_q)
					MODE_QUEUE: begin
						if (found_q) state_d = (count_q >= limit) ? ST_POP : ST_PUSH;
						else state_d = free_v_q ? ST_PUSH : ST_REJECT;
					end
					MODE_LEARN: begin
						if (found_q) state_d = (count_q != '0) ? ST_POP : ST_WRITE;
						else state_d = free_v_q ? ST_WRITE : ST_IDLE;
					end
					MODE_TICK: begin
						if (found_q) state_d = (count_q != '0) ? ST_POP : ST_WRITE;
						else state_d = ST_IDLE;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_POP: state_d = ST_POP_WAIT;
			ST_POP_WAIT: begin
				if (out_free) begin
					if (more) state_d = ST_POP;
					else state_d = (mode_q == MODE_QUEUE) ? ST_PUSH : ST_WRITE;
				end
			end
			ST_PUSH:   state_d = ST_WRITE;
			ST_WRITE:  state_d = ST_IDLE;
			ST_REJECT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			scan_idx_q <= '0;
			chk_v_s1   <= 1'b0;
			found_q    <= 1'b0;
			free_v_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) clr_idx_q <= clr_idx_q + EW'(1);
			if (state_q == ST_IDLE) begin
				scan_idx_q <= '0;
				chk_v_s1   <= 1'b0;
				found_q    <= 1'b0;
				free_v_q   <= 1'b0;
			end
			if (state_q == ST_SCAN) begin
				if (issue_en) scan_idx_q <= scan_idx_q + (EW+1)'(1);
				chk_v_s1 <= issue_en && !(hit || scan_end);
				if (hit) found_q <= 1'b1;
				if (chk_v_s1 && !r_used && !free_v_q) free_v_q <= 1'b1;
			end
			if (out_free) m_tvalid_q <= out_load;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_q   <= s_tuser;
			ip_q     <= s_tdata[31:0];
			handle_q <= s_tdata[47:32];
			mac_q    <= s_tdata[95:48];
			now_q    <= s_tdata[143:96];
		end
		if (state_q == ST_SCAN) begin
			chk_idx_s1 <= scan_idx_q[EW-1:0];
			if (chk_v_s1 && !r_used && !free_v_q) free_idx_q <= chk_idx_s1;
			if (hit) begin
				cur_idx_q <= chk_idx_s1;
				known_q   <= r_known;
				ipw_q     <= r_ip;
				macw_q    <= r_mac;
				dl_q      <= r_dl;
				head_q    <= r_head;
				count_q   <= r_count;
			end
		end
		if (state_q == ST_DECIDE) begin
			if (!found_q && free_v_q) begin
				// open a fresh entry in the lowest free slot
				cur_idx_q <= free_idx_q;
				head_q    <= '0;
				count_q   <= '0;
				ipw_q     <= ip_q;
				macw_q    <= (mode_q == MODE_LEARN) ? mac_q : '0;
				known_q   <= (mode_q == MODE_LEARN);
			end else if (found_q && mode_q == MODE_LEARN) begin
				macw_q  <= mac_q;
				known_q <= 1'b1;
			end
		end
		if (state_q == ST_POP_WAIT && out_free) begin
			head_q  <= head_inc;
			count_q <= cnt_dec;
		end
		if (state_q == ST_PUSH) count_q <= count_q + CW'(1);
		if (out_load) begin
			if (state_q == ST_REJECT) begin
				kind_q  <= KIND_REJECT;
				oh_q    <= handle_q;
				omac_q  <= '0;
				olast_q <= 1'b1;
			end else begin
				kind_q  <= (mode_q == MODE_LEARN) ? KIND_SEND : KIND_DROP;
				oh_q    <= q_rdata;
				omac_q  <= (mode_q == MODE_LEARN) ? macw_q : '0;
				olast_q <= !more;
			end
		end
	end

	// slot memory access
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = cur_idx_q;
		slot_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				slot_we    = 1'b1;
				slot_waddr = clr_idx_q;
			end
			ST_WRITE: begin
				slot_we = 1'b1;
				if (mode_q == MODE_TICK) begin
					// expired slot is freed with an empty queue
					slot_wdata = {dl_q, macw_q, ipw_q, count_q, HW'(0), 1'b0, 1'b0};
				end else begin
					slot_wdata = {new_dl, macw_q, ipw_q, count_q, head_q, known_q, 1'b1};
				end
			end
			default: ;
		endcase
	end
	assign slot_re = issue_en;

	arpc_ram #(
		.DEPTH(ENTRIES),
		.WIDTH(SW),
		.AW   (EW)
	) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.waddr(slot_waddr),
		.wdata(slot_wdata),
		.re   (slot_re),
		.raddr(scan_idx_q[EW-1:0]),
		.rdata(slot_rdata)
	);

	// pending handle memory, one ring of QUEUE_DEPTH per slot
	assign q_re    = (state_q == ST_POP);
	assign q_raddr = q_base + QAW'(head_q);
	assign q_we    = (state_q == ST_PUSH);
	assign q_waddr = q_base + QAW'(pos);

	arpc_ram #(
		.DEPTH(ENTRIES * QUEUE_DEPTH),
		.WIDTH(HDL_W),
		.AW   (QAW)
	) u_queue_ram (
		.clk  (clk),
		.we   (q_we),
		.waddr(q_waddr),
		.wdata(handle_q),
		.re   (q_re),
		.raddr(q_raddr),
		.rdata(q_rdata)
	);

endmodule
`default_nettype wire

FILE: rtl/arpc_checker.sv
// arpc_checker: port level assertions for the arp cache result channel
// depends on arpc_pkg; bound to arp_cache_with_pending_queue_unit below
`default_nettype none
module arpc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata,
	input wire logic [1:0]  m_tuser,
	input wire logic        m_tlast
);
	import arpc_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == KIND_SEND || m_tuser == KIND_DROP ||
			m_tuser == KIND_REJECT))
		else $error("unknown result kind");

	a_mac_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_SEND |-> m_tdata[63:16] == 48'd0)
		else $error("mac on drop or reject");

	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_REJECT |-> m_tlast)
		else $error("reject not final");

endmodule

bind arp_cache_with_pending_queue_unit arpc_checker u_arpc_checker (.*);
`default_nettype wire

FILE: tb/arp_cache_with_pending_queue_unit_tb.sv
// testbench for the arp cache with pending handle queues: random and directed requests
// checked against an in-bench cache model, with random stalls on both streams
// depends on arpc_pkg and the arp_cache_with_pending_queue_unit rtl
`default_nettype none
module arp_cache_with_pending_queue_unit_tb;
	import arpc_pkg::*;

	localparam int SLOTS = 64;
	localparam int QDEPTH = 64;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
	// quiet cycles before a config write, covers a full scan with pops
	localparam int SETTLE_CYCLES = 4 * SLOTS + 40;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] hdl;
		logic [47:0] mac;
		logic        last;
	} arp_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [143:0] s_tdata = '0;   // ip_addr, pkt_handle, mac_addr, now_us
	logic [1:0]   s_tuser = '0;   // mode
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;        // out_handle, dest_mac
	logic [1:0]   m_tuser;        // kind
	logic         m_tlast;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TMO_W-1:0]     cfg_data = '0;

	arp_cache_with_pending_queue_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// cache model state
	logic [MQ_W-1:0]  mdl_max_queued = MAX_QUEUED_RST;
	logic [TMO_W-1:0] mdl_timeout = TIMEOUT_RST;
	bit          ent_used [SLOTS];
	logic [31:0] ent_ip [SLOTS];
	logic [47:0] ent_mac [SLOTS];
	bit          ent_known [SLOTS];
	logic [47:0] ent_deadline [SLOTS];
	logic [15:0] ent_handles [SLOTS][QDEPTH];
	int          ent_head [SLOTS];
	int          ent_count [SLOTS];

	arp_result_t expected_results[$];
	int  mismatches = 0;
	bit  quiet = 1'b0;         // no random idling on either side while set
	bit  hold_req = 1'b0;      // asks the receiver for a long stall
	int  hold_left = 0;
	logic [47:0] clock_us = 48'd0;  // running time for the random phases
	logic [31:0] ip_base;

	initial forever #5 clk = ~clk;

	// run limit, far above the slowest legal run
	initial begin
		#(10 * 4000000);
		$display("Mismatches found");
		$finish;
	end

	function automatic logic [47:0] deadline_from(input logic [47:0] now);
		logic [48:0] sum;
		sum = {1'b0, now} + {9'd0, mdl_timeout};
		return sum[48] ? TIME_MAX : sum[47:0];
	endfunction

	function automatic logic [15:0] pop_handle(input int s);
		logic [15:0] h;
		h = ent_handles[s][ent_head[s]];
		ent_head[s] = (ent_head[s] + 1) % QDEPTH;
		ent_count[s]--;
		return h;
	endfunction

	task automatic add_result(input logic [1:0] kind, input logic [15:0] h,
			input logic [47:0] mac);
		arp_result_t r;
		r.kind = kind;
		r.hdl = h;
		r.mac = mac;
		r.last = 1'b0;
		expected_results.push_back(r);
	endtask

	// apply one accepted request to the model and queue what it should produce
	task automatic cache_update(input logic [1:0] mode, input logic [31:0] ip,
			input logic [15:0] h, input logic [47:0] mac, input logic [47:0] now);
		int s;
		int limit;
		int prev_size;
		prev_size = expected_results.size();
		s = -1;
		if (mode == MODE_QUEUE || mode == MODE_LEARN) begin
			for (int i = 0; i < SLOTS; i++)
				if (ent_used[i] && ent_ip[i] == ip) begin
					s = i;
					break;
				end
		end
		if (mode == MODE_QUEUE) begin
			// zero acts as one, anything above the queue depth as the depth
			limit = (mdl_max_queued == 0) ? 1 : int'(mdl_max_queued);
			if (limit > QDEPTH) limit = QDEPTH;
			if (s < 0) begin
				for (int i = 0; i < SLOTS; i++)
					if (!ent_used[i]) begin
						s = i;
						break;
					end
				if (s < 0) begin
					add_result(KIND_REJECT, h, 48'd0);
				end else begin
					ent_used[s] = 1'b1;
					ent_ip[s] = ip;
					ent_mac[s] = 48'd0;
					ent_known[s] = 1'b0;
					ent_head[s] = 0;
					ent_count[s] = 0;
				end
			end else begin
				while (ent_count[s] >= limit)
					add_result(KIND_DROP, pop_handle(s), 48'd0);
			end
			if (s >= 0) begin
				ent_handles[s][(ent_head[s] + ent_count[s]) % QDEPTH] = h;
				ent_count[s]++;
				ent_deadline[s] = deadline_from(now);
			end
		end else if (mode == MODE_LEARN) begin
			if (s >= 0) begin
				ent_mac[s] = mac;
				ent_known[s] = 1'b1;
				while (ent_count[s] > 0)
					add_result(KIND_SEND, pop_handle(s), mac);
				ent_deadline[s] = deadline_from(now);
			end else begin
				// no entry yet: a known one opens in the lowest free slot; table full: the mac is ignored
				for (int i = 0; i < SLOTS; i++)
					if (!ent_used[i]) begin
						ent_used[i] = 1'b1;
						ent_ip[i] = ip;
						ent_mac[i] = mac;
						ent_known[i] = 1'b1;
						ent_head[i] = 0;
						ent_count[i] = 0;
						ent_deadline[i] = deadline_from(now);
						break;
					end
			end
		end else if (mode == MODE_TICK) begin
			// only the lowest expired slot goes per tick
			for (int i = 0; i < SLOTS; i++)
				if (ent_used[i] && now >= ent_deadline[i]) begin
					while (ent_count[i] > 0)
						add_result(KIND_DROP, pop_handle(i), 48'd0);
					ent_used[i] = 1'b0;
					ent_known[i] = 1'b0;
					ent_head[i] = 0;
					break;
				end
		end
		// the unused mode changes nothing
		if (expected_results.size() > prev_size)
			expected_results[expected_results.size() - 1].last = 1'b1;
	endtask

	// offer one request, with an optional gap first; returns after the accepting edge
	task automatic send_request(input logic [1:0] mode, input logic [31:0] ip,
			input logic [15:0] h, input logic [47:0] mac, input logic [47:0] now);
		if (!quiet && $urandom_range(99) < 31) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {now, mac, h, ip};
		do @(posedge clk); while (!s_tready);
		cache_update(mode, ip, h, mac, now);
	endtask

	// drain all expected results, then let any resultless work finish
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TMO_W-1:0] val);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MAX_QUEUED)
			mdl_max_queued = val[MQ_W-1:0];
		else
			mdl_timeout = val;
	endtask

	// result checker and ready driver
	initial begin
		arp_result_t want;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result kind=%0d handle=%h mac=%h last=%b",
							m_tuser, m_tdata[15:0], m_tdata[63:16], m_tlast);
				end else begin
					want = expected_results.pop_front();
					if (m_tuser !== want.kind || m_tdata[15:0] !== want.hdl ||
							m_tdata[63:16] !== want.mac || m_tlast !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: expected kind=%0d handle=%h mac=%h last=%b, got kind=%0d handle=%h mac=%h last=%b",
								want.kind, want.hdl, want.mac, want.last,
								m_tuser, m_tdata[15:0], m_tdata[63:16], m_tlast);
					end
				end
			end
			if (hold_req) begin
				hold_left = 400;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (quiet) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 31);
			end
		end
	end

	// random traffic over a small pool of addresses so entries get reused
	task automatic random_traffic(input int n_items, input int pool, input int step_max);
		int r;
		logic [31:0] ip;
		for (int k = 0; k < n_items; k++) begin
			r = $urandom_range(99);
			ip = ip_base + $urandom_range(pool - 1);
			clock_us = clock_us + 48'($urandom_range(step_max));
			if (r < 55)
				send_request(MODE_QUEUE, ip, 16'($urandom), 48'({$urandom, $urandom}),
					clock_us);
			else if (r < 77)
				send_request(MODE_LEARN, ip, 16'($urandom), 48'({$urandom, $urandom}),
					clock_us);
			else if (r < 94)
				send_request(MODE_TICK, $urandom, 16'($urandom), 48'({$urandom, $urandom}),
					clock_us);
			else if (r < 96)
				send_request(MODE_UNUSED, ip, 16'($urandom), 48'({$urandom, $urandom}),
					clock_us);
			else
				send_request(MODE_QUEUE, $urandom, 16'($urandom), 48'({$urandom, $urandom}),
					48'({$urandom, $urandom}));
		end
	endtask

	// expire everything still in the table so later phases start empty
	task automatic flush_table();
		bit busy;
		busy = 1'b1;
		while (busy) begin
			busy = 1'b0;
			for (int i = 0; i < SLOTS; i++)
				if (ent_used[i]) busy = 1'b1;
			if (busy)
				send_request(MODE_TICK, $urandom, 16'($urandom), 48'({$urandom, $urandom}),
					TIME_MAX);
		end
	endtask

	// reset values of both registers: long lifetime, forty handles per queue
	task automatic test_reset_config();
		ip_base = $urandom;
		random_traffic(30, 3, 20);
		flush_table();
	endtask

	// field extremes and every mode, first with a one-deep queue and zero lifetime
	task automatic test_directed();
		write_reg(CFG_MAX_QUEUED, 40'd1);
		write_reg(CFG_TIMEOUT, 40'd0);
		send_request(MODE_QUEUE, 32'h0A00_0001, 16'h0000, 48'd0, 48'd100);
		send_request(MODE_QUEUE, 32'h0A00_0001, 16'hFFFF, 48'd0, 48'd100);  // drops oldest
		send_request(MODE_LEARN, 32'h0A00_0001, 16'h0000, TIME_MAX, 48'd101);
		send_request(MODE_QUEUE, 32'h0A00_0001, 16'h1234, 48'd0, 48'd102); // known mac still queues
		send_request(MODE_TICK, 32'h0, 16'h0, 48'd0, 48'd102);  // zero lifetime expires now
		send_request(MODE_LEARN, 32'hFFFF_FFFF, 16'hFFFF, 48'd0, 48'd103);  // new known entry
		send_request(MODE_QUEUE, 32'h0000_0000, 16'h5555, 48'hAAAA_AAAA_AAAA, 48'd103);
		send_request(MODE_UNUSED, 32'h0000_0000, 16'hFFFF, TIME_MAX, TIME_MAX);
		send_request(MODE_TICK, 32'hFFFF_FFFF, 16'h0, 48'd0, 48'd103);
		send_request(MODE_TICK, 32'h0, 16'h0, 48'd0, 48'd103);
		send_request(MODE_TICK, 32'h0, 16'h0, 48'd0, 48'd103);  // nothing left to expire
		write_reg(CFG_MAX_QUEUED, 40'd0);  // acts as one
		write_reg(CFG_TIMEOUT, 40'hFF_FFFF_FFFF);
		send_request(MODE_QUEUE, 32'hC0A8_0001, 16'h00FF, 48'd0, TIME_MAX - 48'd5);  // saturates
		send_request(MODE_QUEUE, 32'hC0A8_0001, 16'hFF00, 48'd0, TIME_MAX - 48'd5);
		send_request(MODE_TICK, 32'h0, 16'h0, 48'd0, TIME_MAX - 48'd1);  // not yet
		send_request(MODE_TICK, 32'h0, 16'h0, 48'd0, TIME_MAX);
		flush_table();
	endtask

	// fill all slots, then a queue is rejected and a learn is ignored
	task automatic test_table_full();
		write_reg(CFG_TIMEOUT, 40'd1000);
		for (int i = 0; i < SLOTS; i++)
			send_request(MODE_LEARN, 32'h1000_0000 + i, 16'($urandom),
				48'({$urandom, $urandom}), 48'd500);
		send_request(MODE_QUEUE, 32'h2000_0000, 16'hBEEF, 48'd0, 48'd501);
		send_request(MODE_LEARN, 32'h2000_0001, 16'h0, 48'h0123_4567_89AB, 48'd501);
		send_request(MODE_QUEUE, 32'h2000_0001, 16'hCAFE, 48'd0, 48'd502);
		send_request(MODE_QUEUE, 32'h1000_003F, 16'hF00D, 48'd0, 48'd502);
		send_request(MODE_LEARN, 32'h1000_003F, 16'h0, 48'hFEDC_BA98_7654, 48'd503);
		flush_table();
	endtask

	// long receiver stall while a full queue drains: the block must back up
	task automatic test_backpressure();
		write_reg(CFG_MAX_QUEUED, 40'd127);  // clamps to the queue depth
		write_reg(CFG_TIMEOUT, 40'd5000);
		quiet = 1'b1;
		for (int i = 0; i < QDEPTH + 6; i++) begin
			if (i == QDEPTH) hold_req = 1'b1;
			send_request(MODE_QUEUE, 32'h3000_0000, 16'($urandom), 48'd0, 48'd10);
		end
		hold_req = 1'b1;
		send_request(MODE_LEARN, 32'h3000_0000, 16'h0, 48'({$urandom, $urandom}), 48'd11);
		for (int i = 0; i < 8; i++)
			send_request(MODE_QUEUE, 32'h3000_0000 + (i % 2), 16'($urandom), 48'd0, 48'd12);
		quiet = 1'b0;
		flush_table();
	endtask

	// random phases across several register settings
	task automatic test_random();
		write_reg(CFG_MAX_QUEUED, 40'd2);
		write_reg(CFG_TIMEOUT, 40'd60);
		ip_base = $urandom;
		random_traffic(15, 6, 15);
		write_reg(CFG_MAX_QUEUED, 40'd100);
		write_reg(CFG_TIMEOUT, 40'd200);
		quiet = 1'b1;
		random_traffic(15, 5, 10);
		quiet = 1'b0;
		write_reg(CFG_MAX_QUEUED, 40'd64);
		write_reg(CFG_TIMEOUT, 40'd1);
		random_traffic(8, 4, 3);
		write_reg(CFG_MAX_QUEUED, 40'd5);
		write_reg(CFG_TIMEOUT, 40'd120);
		random_traffic(10, 8, 12);
		flush_table();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_directed();
		test_table_full();
		test_backpressure();
		test_random();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/arpc_pkg.sv
rtl/arpc_ram.sv
rtl/arp_cache_with_pending_queue_unit.sv
rtl/arpc_checker.sv
tb/arp_cache_with_pending_queue_unit_tb.sv
